### rtl/core/sms_pkg.sv
package sms_pkg;

  localparam int POS_WIDTH   = 32;
  localparam int TIMER_WIDTH = 25;
  localparam int STEP_TIMER_WIDTH = 33;
  // soft limits are 32 bit; compare at whichever width is larger
  localparam int PCMP_WIDTH  = (POS_WIDTH > 32) ? POS_WIDTH : 32;

  localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

  localparam logic [23:0] SETTLE_RESET  = 24'd10000;
  localparam logic [24:0] SEARCH_RESET  = 25'd30000000;
  localparam logic [24:0] RELEASE_RESET = 25'd1000000;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_MOVE   = 3'd1,
    OP_RUN    = 3'd2,
    OP_STOP   = 3'd3,
    OP_HOME   = 3'd4,
    OP_SELECT = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODE_INC = 2'd0,
    MODE_RUN = 2'd1,
    MODE_CAL = 2'd2
  } mode_t;

  // select with this code keeps the pending mode
  localparam logic [1:0] NM_KEEP = 2'd3;

  typedef enum logic [2:0] {
    REG_STEP_INTERVAL   = 3'd0,
    REG_SOFT_MIN        = 3'd1,
    REG_SOFT_MAX        = 3'd2,
    REG_SETTLE_TICKS    = 3'd3,
    REG_SEARCH_TIMEOUT  = 3'd4,
    REG_RELEASE_TIMEOUT = 3'd5
  } reg_idx_t;

  // request flag bit positions
  localparam int REQ_MOVE  = 0;
  localparam int REQ_RUN   = 1;
  localparam int REQ_HOME  = 2;
  localparam int REQ_ABORT = 3;

  typedef struct packed {
    logic [2:0]  op;
    logic [30:0] step_count;
    logic        direction;
    logic [1:0]  next_mode;
    logic        hard_limit;
  } in_item_t;

  typedef struct packed {
    logic               step_pulse;
    logic               dir_out;
    logic               enable_out;
    logic signed [31:0] position_now;
    logic               is_homed;
    logic [1:0]         active_mode;
    logic               at_limit;
    logic               busy_res;
  } out_item_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  idx;
    logic [31:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic empty;
    logic full;
  } obuf_stat_t;

endpackage

### rtl/core/sms_if.sv
interface sms_in_if;
  logic              valid;
  logic              ready;
  sms_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

interface sms_out_if;
  logic               valid;
  logic               ready;
  sms_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

interface sms_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
  modport mon    (input valid, input index, input data, input ready);
endinterface

### rtl/core/sms_core.sv
module sms_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sms_pkg::in_item_t   item,
  input  sms_pkg::cfg_write_t cfg,
  output sms_pkg::out_item_t  result
);
  import sms_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_SETTLE = 3'b010,
    PH_STEP   = 3'b100
  } phase_t;

  typedef enum logic [4:0] {
    HP_IDLE    = 5'b00001,
    HP_SETTLE  = 5'b00010,
    HP_SEARCH  = 5'b00100,
    HP_BACKOFF = 5'b01000,
    HP_ZERO    = 5'b10000
  } home_t;

  // configuration
  logic [31:0]        step_interval;
  logic signed [31:0] soft_min;
  logic signed [31:0] soft_max;
  logic [23:0]        settle_ticks;
  logic [24:0]        search_timeout;
  logic [24:0]        release_timeout;

  // sequencer state
  mode_t                        mode_now, mode_now_next;
  mode_t                        mode_pending, mode_pending_next;
  phase_t                       inc_phase, inc_phase_next;
  phase_t                       run_phase, run_phase_next;
  home_t                        home_phase, home_phase_next;
  logic [2:0]                   entry_done, entry_done_next;
  logic signed [POS_WIDTH-1:0]  position, position_next;
  logic [30:0]                  steps_left, steps_left_next;
  logic                         dir_reg, dir_reg_next;
  logic                         enable_reg, enable_reg_next;
  logic                         homed, homed_next;
  logic [3:0]                   req, req_next;
  logic [TIMER_WIDTH-1:0]       phase_timer, phase_timer_next;
  logic [STEP_TIMER_WIDTH-1:0]  step_timer, step_timer_next;

  logic                         pulse;
  logic                         fc;
  logic                         busy;
  logic signed [PCMP_WIDTH-1:0] pos_cmp;

  function automatic logic signed [POS_WIDTH-1:0] step_pos(
    input logic signed [POS_WIDTH-1:0] pos,
    input logic                        dir
  );
    logic signed [POS_WIDTH-1:0] r;
    r = pos;
    if (dir) begin
      if (pos != POS_MAX) r = pos + POS_WIDTH'(1);
    end else begin
      if (pos != POS_MIN) r = pos - POS_WIDTH'(1);
    end
    return r;
  endfunction

  function automatic logic [3:0] stop_flags(input mode_t m, input logic [3:0] f);
    logic [3:0] r;
    r = f;
    case (m)
      MODE_RUN: r[REQ_RUN]   = 1'b0;
      MODE_CAL: r[REQ_ABORT] = 1'b1;
      default:  r[REQ_MOVE]  = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    mode_now_next     = mode_now;
    mode_pending_next = mode_pending;
    inc_phase_next    = inc_phase;
    run_phase_next    = run_phase;
    home_phase_next   = home_phase;
    entry_done_next   = entry_done;
    position_next     = position;
    steps_left_next   = steps_left;
    dir_reg_next      = dir_reg;
    enable_reg_next   = enable_reg;
    homed_next        = homed;
    req_next          = req;
    phase_timer_next  = phase_timer;
    step_timer_next   = step_timer;
    pulse             = 1'b0;

    // command
    case (item.op)
      OP_MOVE: begin
        steps_left_next           = item.step_count;
        dir_reg_next              = item.direction;
        inc_phase_next            = PH_IDLE;
        entry_done_next[MODE_INC] = 1'b0;
        req_next[REQ_MOVE]        = 1'b1;
      end
      OP_RUN: begin
        req_next[REQ_RUN]         = 1'b1;
        dir_reg_next              = item.direction;
        run_phase_next            = PH_IDLE;
        entry_done_next[MODE_RUN] = 1'b0;
      end
      OP_STOP: req_next = stop_flags(mode_now, req_next);
      OP_HOME: req_next[REQ_HOME] = 1'b1;
      OP_SELECT: begin
        if (item.next_mode != NM_KEEP) mode_pending_next = mode_t'(item.next_mode);
        req_next = stop_flags(mode_now, req_next);
      end
      default: ;
    endcase

    // entry actions of a freshly entered phase
    case (mode_now)
      MODE_INC: begin
        if (!entry_done_next[MODE_INC]) begin
          case (inc_phase_next)
            PH_SETTLE: begin
              phase_timer_next = '0;
              enable_reg_next  = 1'b1;
            end
            PH_STEP: begin
              step_timer_next = '0;
              pulse           = 1'b1;
              position_next   = step_pos(position_next, dir_reg_next);
              if (steps_left_next != '0) steps_left_next = steps_left_next - 31'd1;
            end
            default: enable_reg_next = 1'b0;
          endcase
        end
        entry_done_next[MODE_INC] = 1'b1;
      end
      MODE_RUN: begin
        if (!entry_done_next[MODE_RUN]) begin
          case (run_phase_next)
            PH_SETTLE: begin
              phase_timer_next = '0;
              enable_reg_next  = 1'b1;
            end
            PH_STEP: begin
              step_timer_next = '0;
              pulse           = 1'b1;
              position_next   = step_pos(position_next, dir_reg_next);
            end
            default: enable_reg_next = 1'b0;
          endcase
        end
        entry_done_next[MODE_RUN] = 1'b1;
      end
      MODE_CAL: begin
        if (!entry_done_next[MODE_CAL]) begin
          case (home_phase_next)
            HP_SETTLE: begin
              enable_reg_next  = 1'b1;
              homed_next       = 1'b0;
              dir_reg_next     = 1'b0;
              phase_timer_next = '0;
            end
            HP_SEARCH, HP_BACKOFF: begin
              step_timer_next = '0;
              pulse           = 1'b1;
              position_next   = step_pos(position_next, dir_reg_next);
            end
            HP_ZERO: begin
              homed_next    = 1'b1;
              position_next = '0;
            end
            default: begin
              req_next[REQ_HOME]  = 1'b0;
              req_next[REQ_ABORT] = 1'b0;
              enable_reg_next     = 1'b0;
            end
          endcase
        end
        entry_done_next[MODE_CAL] = 1'b1;
      end
      default: ;
    endcase

    // limits
    pos_cmp = PCMP_WIDTH'(position_next);
    fc = ((item.hard_limit || pos_cmp <= PCMP_WIDTH'(soft_min)) && !dir_reg_next) ||
         (pos_cmp >= PCMP_WIDTH'(soft_max) && dir_reg_next);

    // transitions
    case (mode_now)
      MODE_INC: begin
        if (inc_phase_next == PH_SETTLE) begin
          if (!req_next[REQ_MOVE]) begin
            inc_phase_next = PH_IDLE;
            entry_done_next[MODE_INC] = 1'b0;
          end else if (STEP_TIMER_WIDTH'(phase_timer_next) >=
                       STEP_TIMER_WIDTH'(settle_ticks)) begin
            inc_phase_next = PH_STEP;
            entry_done_next[MODE_INC] = 1'b0;
          end
        end else if (inc_phase_next == PH_STEP) begin
          if (!req_next[REQ_MOVE] || fc || steps_left_next == '0) begin
            inc_phase_next = PH_IDLE;
            entry_done_next[MODE_INC] = 1'b0;
          end else if (step_timer_next >= STEP_TIMER_WIDTH'(step_interval)) begin
            entry_done_next[MODE_INC] = 1'b0;
          end
        end else if (req_next[REQ_MOVE] && steps_left_next != '0 && !fc) begin
          inc_phase_next = PH_SETTLE;
          entry_done_next[MODE_INC] = 1'b0;
        end else if (inc_phase_next != PH_IDLE) begin
          inc_phase_next = PH_IDLE;
          entry_done_next[MODE_INC] = 1'b0;
        end
      end
      MODE_RUN: begin
        if (run_phase_next == PH_SETTLE) begin
          if (!req_next[REQ_RUN]) begin
            run_phase_next = PH_IDLE;
            entry_done_next[MODE_RUN] = 1'b0;
          end else if (STEP_TIMER_WIDTH'(phase_timer_next) >=
                       STEP_TIMER_WIDTH'(settle_ticks)) begin
            run_phase_next = PH_STEP;
            entry_done_next[MODE_RUN] = 1'b0;
          end
        end else if (run_phase_next == PH_STEP) begin
          if (!req_next[REQ_RUN]) begin
            run_phase_next = PH_IDLE;
            entry_done_next[MODE_RUN] = 1'b0;
          end else if (fc) begin
            // hitting a limit also drops the run request
            run_phase_next = PH_IDLE;
            req_next[REQ_RUN] = 1'b0;
            entry_done_next[MODE_RUN] = 1'b0;
          end else if (step_timer_next >= STEP_TIMER_WIDTH'(step_interval)) begin
            entry_done_next[MODE_RUN] = 1'b0;
          end
        end else if (req_next[REQ_RUN] && homed_next && !fc) begin
          run_phase_next = PH_SETTLE;
          entry_done_next[MODE_RUN] = 1'b0;
        end else if (run_phase_next != PH_IDLE) begin
          run_phase_next = PH_IDLE;
          entry_done_next[MODE_RUN] = 1'b0;
        end
      end
      MODE_CAL: begin
        case (home_phase_next)
          HP_IDLE: begin
            if (req_next[REQ_HOME]) begin
              home_phase_next = HP_SETTLE;
              entry_done_next[MODE_CAL] = 1'b0;
            end
          end
          HP_SETTLE: begin
            if (req_next[REQ_ABORT]) begin
              home_phase_next = HP_IDLE;
              entry_done_next[MODE_CAL] = 1'b0;
            end else if (STEP_TIMER_WIDTH'(phase_timer_next) >=
                         STEP_TIMER_WIDTH'(settle_ticks)) begin
              home_phase_next = HP_SEARCH;
              entry_done_next[MODE_CAL] = 1'b0;
            end
          end
          HP_SEARCH: begin
            if (req_next[REQ_ABORT]) begin
              home_phase_next = HP_IDLE;
              entry_done_next[MODE_CAL] = 1'b0;
            end else if (item.hard_limit) begin
              // switch reached: reverse and back off
              dir_reg_next     = ~dir_reg_next;
              phase_timer_next = '0;
              home_phase_next  = HP_BACKOFF;
              entry_done_next[MODE_CAL] = 1'b0;
            end else if (STEP_TIMER_WIDTH'(phase_timer_next) >=
                         STEP_TIMER_WIDTH'(search_timeout)) begin
              home_phase_next = HP_IDLE;
              entry_done_next[MODE_CAL] = 1'b0;
            end else if (step_timer_next >= STEP_TIMER_WIDTH'(step_interval)) begin
              entry_done_next[MODE_CAL] = 1'b0;
            end
          end
          HP_BACKOFF: begin
            if (req_next[REQ_ABORT]) begin
              home_phase_next = HP_IDLE;
              entry_done_next[MODE_CAL] = 1'b0;
            end else if (!item.hard_limit) begin
              home_phase_next = HP_ZERO;
              entry_done_next[MODE_CAL] = 1'b0;
            end else if (STEP_TIMER_WIDTH'(phase_timer_next) >=
                         STEP_TIMER_WIDTH'(release_timeout)) begin
              home_phase_next = HP_IDLE;
              entry_done_next[MODE_CAL] = 1'b0;
            end else if (step_timer_next >= {step_interval, 1'b0}) begin
              entry_done_next[MODE_CAL] = 1'b0;
            end
          end
          default: begin
            home_phase_next = HP_IDLE;
            entry_done_next[MODE_CAL] = 1'b0;
          end
        endcase
      end
      default: ;
    endcase

    // mode switch only from an idle sequence
    case (mode_now)
      MODE_INC: if (inc_phase_next == PH_IDLE) mode_now_next = mode_pending_next;
      MODE_RUN: if (run_phase_next == PH_IDLE) mode_now_next = mode_pending_next;
      MODE_CAL: if (home_phase_next == HP_IDLE) mode_now_next = mode_pending_next;
      default:  mode_now_next = mode_pending_next;
    endcase

    if (phase_timer_next != '1) phase_timer_next = phase_timer_next + TIMER_WIDTH'(1);
    if (step_timer_next != '1) step_timer_next = step_timer_next + STEP_TIMER_WIDTH'(1);

    case (mode_now_next)
      MODE_INC: busy = (inc_phase_next != PH_IDLE);
      MODE_RUN: busy = (run_phase_next != PH_IDLE);
      MODE_CAL: busy = (home_phase_next != HP_IDLE);
      default:  busy = 1'b0;
    endcase

    result.step_pulse   = pulse;
    result.dir_out      = dir_reg_next;
    result.enable_out   = enable_reg_next;
    result.position_now = 32'(position_next);
    result.is_homed     = homed_next;
    result.active_mode  = mode_now_next;
    result.at_limit     = fc;
    result.busy_res     = busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval   <= '0;
      soft_min        <= '0;
      soft_max        <= '0;
      settle_ticks    <= SETTLE_RESET;
      search_timeout  <= SEARCH_RESET;
      release_timeout <= RELEASE_RESET;
    end else if (cfg.we) begin
      case (cfg.idx)
        REG_STEP_INTERVAL:   step_interval   <= cfg.data;
        REG_SOFT_MIN:        soft_min        <= cfg.data;
        REG_SOFT_MAX:        soft_max        <= cfg.data;
        REG_SETTLE_TICKS:    settle_ticks    <= cfg.data[23:0];
        REG_SEARCH_TIMEOUT:  search_timeout  <= cfg.data[24:0];
        REG_RELEASE_TIMEOUT: release_timeout <= cfg.data[24:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_now     <= MODE_INC;
      mode_pending <= MODE_INC;
      inc_phase    <= PH_IDLE;
      run_phase    <= PH_IDLE;
      home_phase   <= HP_IDLE;
      entry_done   <= '0;
      position     <= '0;
      steps_left   <= '0;
      dir_reg      <= 1'b0;
      enable_reg   <= 1'b0;
      homed        <= 1'b0;
      req          <= '0;
      phase_timer  <= '0;
      step_timer   <= '0;
    end else if (push) begin
      mode_now     <= mode_now_next;
      mode_pending <= mode_pending_next;
      inc_phase    <= inc_phase_next;
      run_phase    <= run_phase_next;
      home_phase   <= home_phase_next;
      entry_done   <= entry_done_next;
      position     <= position_next;
      steps_left   <= steps_left_next;
      dir_reg      <= dir_reg_next;
      enable_reg   <= enable_reg_next;
      homed        <= homed_next;
      req          <= req_next;
      phase_timer  <= phase_timer_next;
      step_timer   <= step_timer_next;
    end
  end

endmodule

### rtl/core/sms_obuf.sv
module sms_obuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sms_pkg::out_item_t push_data,
  input  logic               pop,
  output sms_pkg::out_item_t head,
  output sms_pkg::obuf_stat_t stat
);
  import sms_pkg::*;

  out_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.empty = (count == 2'd0);
  assign stat.full  = (count == 2'd2);

endmodule

### rtl/core/stepper_motion_sequencer_top.sv
// Stepper motion sequencer: incremental moves, continuous run and homing.
//
// in_ch carries one beat per 1 us tick: a plain tick or a command (move, run,
// stop, home, select mode) together with the sampled hard limit switch level.
// Every accepted beat produces exactly one beat on out_ch with the step pulse,
// driver direction and enable, position, homed flag, active mode, limit and
// busy status as they stand after that tick.
// cfg_ch writes the six configuration registers by index; it is ready whenever
// rst is low and should only be written while no results are outstanding.
//
// Each result is registered in the result queue and reaches out_ch once
// the results ahead of it are taken. Throughput: one beat per cycle while the
// queue is not full; the whole tick update is a single pass of compare/count
// logic from the sequencer state registers into a two-entry result queue.
// When out_ch stalls, the queue holds up to two results and in_ch.ready
// drops only once both are waiting.
// Reset (rst, synchronous) holds in_ch and cfg_ch not ready, empties the
// queue, returns all sequences to idle in incremental mode, and loads the
// configuration reset values.
module stepper_motion_sequencer_top (
  input  logic      clk,
  input  logic      rst,
  sms_in_if.sink    in_ch,
  sms_out_if.source out_ch,
  sms_cfg_if.sink   cfg_ch
);
  import sms_pkg::*;

  logic       push;
  out_item_t  result;
  cfg_write_t cfg_wr;
  obuf_stat_t ob_stat;

  assign in_ch.ready  = !rst && !ob_stat.full;
  assign push         = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = !rst;

  assign cfg_wr.we   = cfg_ch.valid && cfg_ch.ready;
  assign cfg_wr.idx  = cfg_ch.index;
  assign cfg_wr.data = cfg_ch.data;

  sms_core u_core (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (in_ch.data),
    .cfg    (cfg_wr),
    .result (result)
  );

  sms_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .pop       (out_ch.valid && out_ch.ready),
    .head      (out_ch.data),
    .stat      (ob_stat)
  );

  assign out_ch.valid = !ob_stat.empty;

endmodule

### rtl/core/sms_chk.sv
module sms_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input sms_pkg::out_item_t out_data
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // input is only throttled when results are backed up
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("accepted beat produced no result");

endmodule

bind stepper_motion_sequencer_top sms_chk u_sms_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
